@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock outside reset
`define GCRD_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define GCRD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/gcrd_pkg.sv @@
// ---------------------------------------------------------------------------
// gcrd_pkg
// Types, constants and tables for the great-circle distance block.
// ---------------------------------------------------------------------------
package gcrd_pkg;

    localparam int TAB_LEN = 24;
    localparam int TAB_IW  = 5;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [33:0] GAIN_INV    = 34'sd652032874;
    localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
    localparam logic signed [32:0] EARTH_MILES = 33'sd3963;
    localparam logic [21:0]        SEG_MAX     = 22'h3FFFFF;
    localparam logic [39:0]        TOTAL_MAX   = 40'hFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE, S_SC_START, S_SC_WAIT, S_M1, S_M2, S_M3, S_SUM, S_SQ,
        S_SQRT_START, S_SQRT_WAIT, S_ACOS_START, S_ACOS_WAIT, S_ANG,
        S_DIST, S_ACC
    } t_state;

    typedef enum logic [2:0] {
        C_IDLE, C_RED0, C_RED1, C_FOLD, C_ITER
    } t_cstate;

    typedef struct packed {
        logic start;
        logic vec;
    } t_cordic_cmd;

    function automatic logic signed [35:0] atan_q30(input logic [TAB_IW-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return $signed({4'b0, v});
    endfunction

    // Q.30 product rounded back to Q.30
    function automatic logic signed [35:0] rnd_q30(input logic signed [65:0] p);
        logic signed [65:0] s;
        s = p + 66'sd536870912;
        return s[65:30];
    endfunction

endpackage

@@ rtl/gcrd_mul.sv @@
// ---------------------------------------------------------------------------
// gcrd_mul
// Shared signed multiplier with registered product.
// ---------------------------------------------------------------------------
module gcrd_mul
    import gcrd_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

@@ rtl/gcrd_isqrt.sv @@
// ---------------------------------------------------------------------------
// gcrd_isqrt
// Bit-serial integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module gcrd_isqrt
    import gcrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [60:0] i_v,
    output logic        o_done,
    output logic [30:0] o_res
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [60:0] r_v, n_v;
    logic [61:0] r_res, n_res;
    logic [60:0] r_bit, n_bit;
    logic [61:0] sum;

    always_comb begin
        sum    = r_res + {1'b0, r_bit};
        n_busy = r_busy;
        n_done = 1'b0;
        n_v    = r_v;
        n_res  = r_res;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_v    = i_v;
            n_res  = '0;
            n_bit  = 61'h1000_0000_0000_0000;
        end else if (r_busy) begin
            if ({1'b0, r_v} >= sum) begin
                n_v   = r_v - sum[60:0];
                n_res = (r_res >> 1) + {1'b0, r_bit};
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit == 61'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_v   <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_res  = r_res[30:0];
endmodule

@@ rtl/gcrd_cordic.sv @@
// ---------------------------------------------------------------------------
// gcrd_cordic
// Iterative CORDIC: rotation (sin/cos with angle reduction) or vectoring.
// ---------------------------------------------------------------------------
module gcrd_cordic
    import gcrd_pkg::*;
#(
    parameter int ITERS = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cordic_cmd        i_cmd,
    input  logic signed [35:0] i_angle,
    input  logic signed [33:0] i_x,
    input  logic signed [33:0] i_y,
    output logic               o_done,
    output logic signed [33:0] o_x,
    output logic signed [33:0] o_y,
    output logic signed [35:0] o_z
);
    t_cstate r_st, n_st;
    logic    r_done, n_done;
    logic    r_vec, n_vec;
    logic    r_neg, n_neg;
    logic signed [33:0] r_x, n_x, r_y, n_y, dx, dy;
    logic signed [35:0] r_z, n_z, at;
    logic [TAB_IW-1:0]  r_k, n_k;
    logic dir;
    logic last;

    assign last = (r_k == TAB_IW'(ITERS - 1));

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            C_IDLE: if (i_cmd.start) n_st = i_cmd.vec ? C_ITER : C_RED0;
            C_RED0: n_st = C_RED1;
            C_RED1: n_st = C_FOLD;
            C_FOLD: n_st = C_ITER;
            C_ITER: if (last) n_st = C_IDLE;
            default: n_st = C_IDLE;
        endcase
    end

    always_comb begin
        dx     = r_y >>> r_k;
        dy     = r_x >>> r_k;
        at     = atan_q30(r_k);
        dir    = r_vec ? (!r_y[33] && (r_y != '0)) : !r_z[35];
        n_done = 1'b0;
        n_vec  = r_vec;
        n_neg  = r_neg;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_k    = r_k;
        unique case (r_st)
            C_IDLE: begin
                if (i_cmd.start) begin
                    n_vec = i_cmd.vec;
                    n_neg = 1'b0;
                    n_k   = '0;
                    if (i_cmd.vec) begin
                        n_x = i_x;
                        n_y = i_y;
                        n_z = '0;
                    end else begin
                        n_x = GAIN_INV;
                        n_y = '0;
                        n_z = i_angle;
                    end
                end
            end
            C_RED0, C_RED1: begin
                if (r_z > PI_Q30) n_z = r_z - TWO_PI_Q30;
                else if (r_z < -PI_Q30) n_z = r_z + TWO_PI_Q30;
            end
            C_FOLD: begin
                if (r_z > HALF_PI_Q30) begin
                    n_z   = r_z - PI_Q30;
                    n_neg = 1'b1;
                end else if (r_z < -HALF_PI_Q30) begin
                    n_z   = r_z + PI_Q30;
                    n_neg = 1'b1;
                end
            end
            C_ITER: begin
                if (dir ^ r_vec) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                end
                n_z    = (dir ^ r_vec) ? r_z - at : r_z + at;
                n_k    = r_k + 1'b1;
                n_done = last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= C_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_vec <= n_vec;
        r_neg <= n_neg;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_k   <= n_k;
    end

    assign o_done = r_done;
    assign o_x    = r_neg ? -r_x : r_x;
    assign o_y    = r_neg ? -r_y : r_y;
    assign o_z    = r_z;
endmodule

@@ rtl/great_circle_route_distance.sv @@
// ---------------------------------------------------------------------------
// great_circle_route_distance
// Great-circle segment distance and saturating route total per waypoint.
// ---------------------------------------------------------------------------
// One waypoint word at a time; s_axis_tready is high only while the sequencer
// is idle. A first-point word (or any word before a route exists) is accepted
// and gives no result. Any other word runs three sin/cos CORDIC passes, five
// products on the shared multiplier, a square root and one vectoring CORDIC
// pass; the next word is not accepted until the result word is registered,
// which waits for the previous result word to be taken.
module great_circle_route_distance
    import gcrd_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [18:0] latitude, [37:19] longitude
    input  logic        s_axis_tuser,  // [0] first_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [21:0] segment_distance, [61:22] route_total
    output logic        m_axis_tuser   // [0] total_saturated
);
    t_state r_state, n_state;

    logic signed [18:0] r_prev_lat, r_prev_lon, r_lat, r_lon;
    logic               r_have;
    logic [39:0]        r_total;
    logic [1:0]         r_op;
    logic signed [32:0] r_sin [3];
    logic signed [32:0] r_cos [3];
    logic signed [35:0] r_p1;
    logic signed [32:0] r_t;
    logic [30:0]        r_sq;
    logic signed [35:0] r_z;
    logic [31:0]        r_ang;
    logic               r_ovalid;
    logic [21:0]        r_oseg;
    logic [39:0]        r_otot;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [35:0] p_rnd;
    t_cordic_cmd        c_cmd;
    logic signed [35:0] c_angle;
    logic               c_done;
    logic signed [33:0] c_x, c_y;
    logic signed [35:0] c_z;
    logic               q_start, q_done;
    logic [30:0]        q_res;
    logic [60:0]        q_v;

    logic               acc;
    logic               first;
    logic signed [19:0] dlon;
    logic signed [33:0] t_sum;
    logic [30:0]        t_mag;
    logic signed [35:0] z_pos, z_adj;
    logic [44:0]        seg_sum;
    logic [21:0]        seg;
    logic [40:0]        tot_sum;
    logic [39:0]        tot;
    logic               out_free;

    assign acc      = s_axis_tvalid && s_axis_tready;
    assign first    = s_axis_tuser || !r_have;
    assign p_rnd    = rnd_q30(mul_p);
    assign dlon     = {r_lon[18], r_lon} - {r_prev_lon[18], r_prev_lon};
    assign t_mag    = r_t[32] ? 31'(-r_t) : r_t[30:0];
    assign out_free = !r_ovalid || m_axis_tready;

    gcrd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    gcrd_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (c_cmd),
        .i_angle (c_angle),
        .i_x     ({3'b0, t_mag}),
        .i_y     ({3'b0, r_sq}),
        .o_done  (c_done),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z)
    );

    gcrd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (q_start),
        .i_v     (q_v),
        .o_done  (q_done),
        .o_res   (q_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (acc && !first) n_state = S_SC_START;
            S_SC_START:   n_state = S_SC_WAIT;
            S_SC_WAIT:    if (c_done) n_state = (r_op == 2'd2) ? S_M1 : S_SC_START;
            S_M1:         n_state = S_M2;
            S_M2:         n_state = S_M3;
            S_M3:         n_state = S_SUM;
            S_SUM:        n_state = S_SQ;
            S_SQ:         n_state = S_SQRT_START;
            S_SQRT_START: n_state = S_SQRT_WAIT;
            S_SQRT_WAIT:  if (q_done) n_state = S_ACOS_START;
            S_ACOS_START: n_state = S_ACOS_WAIT;
            S_ACOS_WAIT:  if (c_done) n_state = S_ANG;
            S_ANG:        n_state = S_DIST;
            S_DIST:       n_state = S_ACC;
            S_ACC:        if (out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        c_cmd.start   = (r_state == S_SC_START) || (r_state == S_ACOS_START);
        c_cmd.vec     = (r_state == S_ACOS_START);
        q_start       = (r_state == S_SQRT_START);
        q_v           = 61'h1000_0000_0000_0000 - mul_p[60:0];
        unique case (r_op)
            2'd0:    c_angle = {{3{r_prev_lat[18]}}, r_prev_lat, 14'b0};
            2'd1:    c_angle = {{3{r_lat[18]}}, r_lat, 14'b0};
            default: c_angle = {{2{dlon[19]}}, dlon, 14'b0};
        endcase
        unique case (r_state)
            S_M1: begin
                mul_a = r_sin[0];
                mul_b = r_sin[1];
            end
            S_M2: begin
                mul_a = r_cos[0];
                mul_b = r_cos[1];
            end
            S_M3: begin
                mul_a = p_rnd[32:0];
                mul_b = r_cos[2];
            end
            S_SQ: begin
                mul_a = {2'b0, t_mag};
                mul_b = {2'b0, t_mag};
            end
            // distance product is held while the result waits
            S_DIST, S_ACC: begin
                mul_a = {1'b0, r_ang};
                mul_b = EARTH_MILES;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        t_sum = 34'(r_p1) + 34'(p_rnd);
        z_pos = c_z[35] ? '0 : c_z;
        z_adj = r_t[32] ? PI_Q30 - r_z : r_z;
        seg_sum = mul_p[44:0] + 45'd2097152;
        seg     = (seg_sum[44:22] > {1'b0, SEG_MAX}) ? SEG_MAX : seg_sum[43:22];
        tot_sum = {1'b0, r_total} + {19'b0, seg};
        tot     = tot_sum[40] ? TOTAL_MAX : tot_sum[39:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_have     <= 1'b0;
            r_total    <= '0;
            r_prev_lat <= '0;
            r_prev_lon <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (acc) begin
                r_lat <= s_axis_tdata[18:0];
                r_lon <= s_axis_tdata[37:19];
                if (first) begin
                    r_prev_lat <= s_axis_tdata[18:0];
                    r_prev_lon <= s_axis_tdata[37:19];
                    r_have     <= 1'b1;
                    r_total    <= '0;
                end
                r_op <= 2'd0;
            end
            if (r_state == S_SC_WAIT && c_done) begin
                r_sin[r_op] <= c_y[32:0];
                r_cos[r_op] <= c_x[32:0];
                r_op        <= r_op + 2'd1;
            end
            if (r_state == S_M2) r_p1 <= p_rnd;
            if (r_state == S_SUM) begin
                if (t_sum > 34'(ONE_Q30)) r_t <= ONE_Q30;
                else if (t_sum < -34'(ONE_Q30)) r_t <= -ONE_Q30;
                else r_t <= t_sum[32:0];
            end
            if (r_state == S_SQRT_WAIT && q_done) r_sq <= q_res;
            if (r_state == S_ACOS_WAIT && c_done) r_z <= z_pos;
            if (r_state == S_ANG) begin
                if (z_adj[35]) r_ang <= '0;
                else if (z_adj > PI_Q30) r_ang <= PI_Q30[31:0];
                else r_ang <= z_adj[31:0];
            end
            if (r_state == S_ACC && out_free) begin
                r_ovalid   <= 1'b1;
                r_oseg     <= seg;
                r_otot     <= tot;
                r_total    <= tot;
                r_prev_lat <= r_lat;
                r_prev_lon <= r_lon;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b0, r_otot, r_oseg};
    assign m_axis_tuser  = (r_otot == TOTAL_MAX);

`include "assert_macros.svh"

    `GCRD_ASSERT_IMP(a_cordic_done_owned, c_done,
        (r_state == S_SC_WAIT) || (r_state == S_ACOS_WAIT), "cordic done while not waiting")
    `GCRD_ASSERT_IMP(a_sqrt_done_owned, q_done, r_state == S_SQRT_WAIT,
        "sqrt done while not waiting")
    `GCRD_ASSERT(a_ready_only_idle, !s_axis_tready || (r_state == S_IDLE),
        "ready outside idle")
    `GCRD_ASSERT_IMP(a_op_range, r_state == S_SC_WAIT, r_op != 2'd3, "bad cordic op")
endmodule

@@ test/great_circle_route_distance_tb.sv @@
// ---------------------------------------------------------------------------
// great_circle_route_distance_tb
// Self-checking bench for the great-circle route distance block.
// Sends waypoint words with random gaps, stalls the result side at random,
// and compares every result word to a fixed-point predictor of the distance
// and route-total math.
// ---------------------------------------------------------------------------
class route_scoreboard;
    localparam int ITERS = 18;
    localparam longint PI = 64'sd3373259426;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint TWO_PI = 64'sd6746518852;
    localparam longint ONE = 64'sd1073741824;
    localparam longint TOT_MAX = 64'hFF_FFFF_FFFF;

    longint prev_lat, prev_lon, total;
    bit     have_prev;
    logic [21:0] seg_q[$];
    logic [39:0] tot_q[$];
    logic        sat_q[$];
    int          errors;

    function new();
        prev_lat = 0; prev_lon = 0; total = 0; have_prev = 0; errors = 0;
    endfunction

    function longint atan_at(int k);
        longint tab[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
            64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
            64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
            64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return tab[k];
    endfunction

    function longint mul_round(longint a, longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function void sin_cos(longint a, output longint s, output longint c);
        bit     neg;
        longint x, y, z, dx, dy;
        neg = 0; x = 64'sd652032874; y = 0;
        for (int k = 0; k < 2; k++) begin
            if (a > PI) a -= TWO_PI;
            else if (a < -PI) a += TWO_PI;
        end
        if (a > HALF_PI) begin
            a -= PI; neg = 1;
        end else if (a < -HALF_PI) begin
            a += PI; neg = 1;
        end
        z = a;
        for (int k = 0; k < ITERS; k++) begin
            dx = y >>> k; dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_at(k);
            end else begin
                x += dx; y -= dy; z += atan_at(k);
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b; res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function longint arc_cos(longint t);
        longint unsigned m;
        longint x, y, z, dx, dy;
        m = (t < 0) ? -t : t;
        x = m;
        y = int_sqrt((64'd1 << 60) - m * m);
        z = 0;
        for (int k = 0; k < ITERS; k++) begin
            dx = y >>> k; dy = x >>> k;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_at(k);
            end else begin
                x -= dx; y += dy; z -= atan_at(k);
            end
        end
        if (z < 0) z = 0;
        if (t < 0) z = PI - z;
        if (z < 0) z = 0;
        if (z > PI) z = PI;
        return z;
    endfunction

    function void note_waypoint(logic signed [18:0] lat_in, logic signed [18:0] lon_in,
                                bit first);
        longint lat, lon, s1, c1, s2, c2, sb, cb, t, seg;
        lat = lat_in; lon = lon_in;
        if (first || !have_prev) begin
            prev_lat = lat; prev_lon = lon; have_prev = 1; total = 0;
            return;
        end
        sin_cos(prev_lat * 16384, s1, c1);
        sin_cos(lat * 16384, s2, c2);
        sin_cos((lon - prev_lon) * 16384, sb, cb);
        t = mul_round(s1, s2) + mul_round(mul_round(c1, c2), cb);
        if (t > ONE) t = ONE;
        if (t < -ONE) t = -ONE;
        seg = (64'sd3963 * arc_cos(t) + (64'sd1 << 21)) >>> 22;
        if (seg > 64'h3FFFFF) seg = 64'h3FFFFF;
        total += seg;
        if (total > TOT_MAX) total = TOT_MAX;
        prev_lat = lat; prev_lon = lon;
        seg_q.push_back(seg[21:0]);
        tot_q.push_back(total[39:0]);
        sat_q.push_back(total == TOT_MAX);
    endfunction

    task report(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task check_word(logic [63:0] data, logic user);
        logic [21:0] seg;
        logic [39:0] tot;
        logic        sat;
        if (seg_q.size() == 0) begin
            $display("%0t unexpected result word %h", $realtime, data);
            errors++;
            return;
        end
        seg = seg_q.pop_front(); tot = tot_q.pop_front(); sat = sat_q.pop_front();
        if (data[21:0] !== seg) report("segment_distance", data[21:0], seg);
        if (data[61:22] !== tot) report("route_total", data[61:22], tot);
        if (user !== sat) report("total_saturated", user, sat);
    endtask
endclass

module great_circle_route_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1900;
    localparam int RANGE_MAX = 205887;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    route_scoreboard sb = new();
    bit sending_done = 0;
    bit quiet_mode = 0;

    great_circle_route_distance u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic int pick_gap();
        if (quiet_mode || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [18:0] rand_angle();
        if ($urandom_range(0, 9) < 7) return 19'($urandom_range(0, 2 * RANGE_MAX) - RANGE_MAX);
        return 19'($urandom);
    endfunction

    task automatic send_waypoint(logic [18:0] lat, logic [18:0] lon, bit first);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {2'b00, lon, lat};
        s_axis_tuser  <= first;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_waypoint(lat, lon, first);
    endtask

    initial begin
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // non-first word with no route yet acts as a first point
        send_waypoint(19'sd0, 19'sd0, 0);
        send_waypoint(19'sd0, 19'sd0, 0);
        send_waypoint(19'(RANGE_MAX), 19'(RANGE_MAX), 0);
        send_waypoint(19'(-RANGE_MAX), 19'(-RANGE_MAX), 0);
        send_waypoint(19'h3FFFF, 19'h3FFFF, 0);
        send_waypoint(19'h40000, 19'h40000, 0);
        send_waypoint(19'h40000, 19'h3FFFF, 0);
        send_waypoint(19'h7FFFF, 19'h00001, 1);
        send_waypoint(19'h7FFFF, 19'h00001, 0);
        // antipodal pair drives the cosine argument to minus one
        send_waypoint(19'sd0, 19'sd0, 1);
        send_waypoint(19'sd0, 19'sd205887, 0);
        send_waypoint(19'sd102944, 19'sd0, 1);
        send_waypoint(-19'sd102944, 19'sd0, 0);
        send_waypoint(19'sd50000, -19'sd60000, 0);
        send_waypoint(19'sd50001, -19'sd60000, 0);
        n = 0;
        while (n < RANDOM_WORDS) begin
            if (n % 150 == 0) quiet_mode = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 19) == 0) begin
                send_waypoint(rand_angle(), rand_angle(), 1);
                n++;
            end else begin
                send_waypoint(rand_angle(), rand_angle(), $urandom_range(0, 30) == 0);
                n++;
            end
        end
        s_axis_tvalid <= 0;
        sending_done = 1;
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_word(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin
        wait (sending_done);
        while (sb.seg_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
